>>> sv/bfscc_pkg.sv
// ----------------------------------------------------------------------------
// bfscc_pkg: shared types and constants for the centrality search block
// Field widths, request and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package bfscc_pkg;

   // payload field widths
   localparam int NODE_W   = 10;
   localparam int LVL_W    = 10;
   localparam int ENT_W    = LVL_W + 1;   // {visited, level}
   localparam int CNT_W    = 11;          // node_count range
   localparam int REACH_W  = 10;
   localparam int SUM_W    = 20;
   localparam int HSUM_W   = 36;
   localparam int FAR_W    = 26;
   localparam int RATIO_W  = 17;
   localparam int STATUS_W = 2;

   // shared divider sizes
   localparam int DIV_NW = 40;
   localparam int DIV_DW = 26;
   localparam int DIV_CW = 6;

   // saturation limits
   localparam logic [FAR_W-1:0]   FAR_MAX   = {FAR_W{1'b1}};
   localparam logic [RATIO_W-1:0] RATIO_MAX = 17'h10000;

   // request codes
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_SRC = 2'd2;

   // register indexes
   localparam logic CSR_HYP    = 1'b0;
   localparam logic CSR_NCOUNT = 1'b1;

   typedef enum logic [4:0] {
      ST_RST_CLR,
      ST_IDLE,
      ST_MCLR,
      ST_SRC_WAIT,
      ST_SRC_CHK,
      ST_NCLR,
      ST_SRC_SET,
      ST_E_RD,
      ST_E_A,
      ST_E_B,
      ST_E_UPD,
      ST_LVL_END,
      ST_ACC_RD,
      ST_ACC_CHK,
      ST_ACC_DIV,
      ST_FAR,
      ST_FAR_W,
      ST_CLO,
      ST_CLO_W,
      ST_HARM,
      ST_HARM_W,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> sv/bfscc_ram.sv
// ----------------------------------------------------------------------------
// bfscc_ram: generic single-write, single-read memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bfscc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> sv/bfscc_div.sv
// ----------------------------------------------------------------------------
// bfscc_div: shared restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module bfscc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [bfscc_pkg::DIV_NW-1:0]  dividend,
   input  wire logic [bfscc_pkg::DIV_DW-1:0]  divisor,
   output logic                               done,
   output logic      [bfscc_pkg::DIV_NW-1:0]  quotient
);

   logic [bfscc_pkg::DIV_NW-1:0] quo_ff, quo_in;
   logic [bfscc_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [bfscc_pkg::DIV_DW-1:0] dsr_ff, dsr_in;
   logic [bfscc_pkg::DIV_CW-1:0] cnt_ff, cnt_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [bfscc_pkg::DIV_DW:0]   trial;
   logic [bfscc_pkg::DIV_DW:0]   diff;
   logic                         ge;

   // one restoring step
   always_comb begin
      trial  = {rem_ff, quo_ff[bfscc_pkg::DIV_NW-1]};
      ge     = (trial >= {1'b0, dsr_ff});
      diff   = trial - {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[bfscc_pkg::DIV_DW-1:0] : trial[bfscc_pkg::DIV_DW-1:0];
         quo_in = {quo_ff[bfscc_pkg::DIV_NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bfscc_pkg::DIV_CW'(bfscc_pkg::DIV_NW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/bfs_closeness_harmonic_centrality_top.sv
// Query: level store clear and source write, then sweeps of the edge list level
//   by level until no node changes, a scan of the nodes below the node count
//   with one division per reached node, up to 3 final divisions, and output;
//   hypergraph adds a source member check.
// Throughput: one word at a time; ready only while the sequencer is idle.
// Reset: synchronous; the member store is then swept clear.
// ----------------------------------------------------------------------------
// bfs_closeness_harmonic_centrality_top: BFS closeness / harmonic centrality
// Edge memory, member marks and level store in RAM; a sequencer sweeps edges
// level by level, then scans nodes and divides on one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_closeness_harmonic_centrality_top #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 8192
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_type,
   input  wire logic [bfscc_pkg::NODE_W-1:0]        req_node_a,
   input  wire logic [bfscc_pkg::NODE_W-1:0]        req_node_b,
   input  wire logic                                req_mark_a,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [bfscc_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [bfscc_pkg::FAR_W-1:0]         rsp_farness_value,
   output logic      [bfscc_pkg::RATIO_W-1:0]       rsp_closeness_value,
   output logic      [bfscc_pkg::RATIO_W-1:0]       rsp_harmonic_value,
   output logic      [bfscc_pkg::REACH_W-1:0]       rsp_reachable_count,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire logic                                csr_index,
   input  wire logic [bfscc_pkg::CNT_W-1:0]         csr_wdata
);

   localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EW      = $clog2(MAX_EDGES + 1);

   bfscc_pkg::state_type state_ff, state_in;

   logic                              hyp_ff, hyp_in;
   logic [bfscc_pkg::CNT_W-1:0]       ncount_ff, ncount_in;
   logic [EW-1:0]                     etot_ff, etot_in;
   logic [EW-1:0]                     eidx_ff, eidx_in;
   logic [NODE_AW-1:0]                clr_ff, clr_in;
   logic [bfscc_pkg::NODE_W-1:0]      src_ff, src_in;
   logic [bfscc_pkg::LVL_W-1:0]       lvl_ff, lvl_in;
   logic                              chg_ff, chg_in;
   logic [bfscc_pkg::ENT_W-1:0]       enta_ff, enta_in;
   logic [bfscc_pkg::CNT_W-1:0]       scan_ff, scan_in;
   logic [bfscc_pkg::CNT_W-1:0]       total_ff, total_in;
   logic [bfscc_pkg::REACH_W-1:0]     reach_ff, reach_in;
   logic [bfscc_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [bfscc_pkg::HSUM_W-1:0]      hsum_ff, hsum_in;
   logic [bfscc_pkg::FAR_W-1:0]       far_ff, far_in;
   logic [bfscc_pkg::RATIO_W-1:0]     clo_ff, clo_in;
   logic [bfscc_pkg::RATIO_W-1:0]     harm_ff, harm_in;
   logic [bfscc_pkg::STATUS_W-1:0]    stat_ff, stat_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bfscc_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [bfscc_pkg::FAR_W-1:0]       rsp_far_ff;
   logic [bfscc_pkg::RATIO_W-1:0]     rsp_clo_ff;
   logic [bfscc_pkg::RATIO_W-1:0]     rsp_harm_ff;
   logic [bfscc_pkg::REACH_W-1:0]     rsp_reach_ff;
   logic                              rsp_load;

   // memory ports
   logic                              edge_we;
   logic [2*bfscc_pkg::NODE_W-1:0]    edge_q;
   logic                              mem_we;
   logic [NODE_AW-1:0]                mem_waddr;
   logic                              mem_wdata;
   logic [NODE_AW-1:0]                mem_raddr;
   logic                              mem_q;
   logic                              ent_we;
   logic [NODE_AW-1:0]                ent_waddr;
   logic [bfscc_pkg::ENT_W-1:0]       ent_wdata;
   logic [NODE_AW-1:0]                ent_raddr;
   logic [bfscc_pkg::ENT_W-1:0]       ent_q;

   // divider port
   logic                              div_start;
   logic [bfscc_pkg::DIV_NW-1:0]      div_num;
   logic [bfscc_pkg::DIV_DW-1:0]      div_den;
   logic                              div_done;
   logic [bfscc_pkg::DIV_NW-1:0]      div_quo;

   // decoded helpers
   logic [bfscc_pkg::CNT_W-1:0]       neff;
   logic [bfscc_pkg::NODE_W-1:0]      e_a, e_b;
   logic                              e_ok;
   logic                              clr_last;
   logic                              a_cur, b_cur;
   logic                              counted, reached;

   assign e_a      = edge_q[2*bfscc_pkg::NODE_W-1:bfscc_pkg::NODE_W];
   assign e_b      = edge_q[bfscc_pkg::NODE_W-1:0];
   assign e_ok     = (32'(e_a) < MAX_NODES) && (32'(e_b) < MAX_NODES);
   assign clr_last = (clr_ff == NODE_AW'(MAX_NODES - 1));
   assign neff     = (32'(ncount_ff) < MAX_NODES) ? ncount_ff
                                                   : bfscc_pkg::CNT_W'(MAX_NODES);

   // read address selection
   always_comb begin
      unique case (state_ff)
         bfscc_pkg::ST_E_A: ent_raddr = NODE_AW'(e_a);
         bfscc_pkg::ST_E_B: ent_raddr = NODE_AW'(e_b);
         default:           ent_raddr = NODE_AW'(scan_ff);
      endcase
      mem_raddr = (state_ff == bfscc_pkg::ST_ACC_RD) ? NODE_AW'(scan_ff)
                                                     : NODE_AW'(src_ff);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      hyp_in    = hyp_ff;
      ncount_in = ncount_ff;
      etot_in   = etot_ff;
      eidx_in   = eidx_ff;
      clr_in    = clr_ff;
      src_in    = src_ff;
      lvl_in    = lvl_ff;
      chg_in    = chg_ff;
      enta_in   = enta_ff;
      scan_in   = scan_ff;
      total_in  = total_ff;
      reach_in  = reach_ff;
      sum_in    = sum_ff;
      hsum_in   = hsum_ff;
      far_in    = far_ff;
      clo_in    = clo_ff;
      harm_in   = harm_ff;
      stat_in   = stat_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      edge_we   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = 1'b0;
      ent_we    = 1'b0;
      ent_waddr = clr_ff;
      ent_wdata = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      a_cur     = enta_ff[bfscc_pkg::LVL_W] && (enta_ff[bfscc_pkg::LVL_W-1:0] == lvl_ff);
      b_cur     = ent_q[bfscc_pkg::LVL_W] && (ent_q[bfscc_pkg::LVL_W-1:0] == lvl_ff);
      counted   = !hyp_ff || mem_q;
      reached   = counted && ent_q[bfscc_pkg::LVL_W]
                  && (scan_ff != bfscc_pkg::CNT_W'(src_ff))
                  && (ent_q[bfscc_pkg::LVL_W-1:0] != '0);

      // register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            bfscc_pkg::CSR_HYP:    hyp_in    = csr_wdata[0];
            bfscc_pkg::CSR_NCOUNT: ncount_in = csr_wdata;
            default:               hyp_in    = hyp_ff;
         endcase
      end

      unique case (state_ff)
         // member store sweep (after reset and on clear)
         bfscc_pkg::ST_RST_CLR, bfscc_pkg::ST_MCLR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_last) begin
               clr_in   = '0;
               state_in = (state_ff == bfscc_pkg::ST_RST_CLR) ? bfscc_pkg::ST_IDLE
                                                              : bfscc_pkg::ST_OUT;
            end
         end

         bfscc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               stat_in  = bfscc_pkg::STAT_OK;
               far_in   = '0;
               clo_in   = '0;
               harm_in  = '0;
               reach_in = '0;
               sum_in   = '0;
               hsum_in  = '0;
               total_in = '0;
               src_in   = req_node_a;
               state_in = bfscc_pkg::ST_OUT;
               priority case (req_type)
                  bfscc_pkg::REQ_ADD: begin
                     if (32'(etot_ff) >= MAX_EDGES) begin
                        stat_in = bfscc_pkg::STAT_FULL;
                     end else begin
                        edge_we = 1'b1;
                        etot_in = etot_ff + 1'b1;
                        if (req_mark_a && (32'(req_node_a) < MAX_NODES)) begin
                           mem_we    = 1'b1;
                           mem_waddr = NODE_AW'(req_node_a);
                           mem_wdata = 1'b1;
                        end
                     end
                  end
                  bfscc_pkg::REQ_QUERY: begin
                     if (32'(req_node_a) >= 32'(neff)) begin
                        stat_in = bfscc_pkg::STAT_BAD_SRC;
                     end else if (hyp_ff) begin
                        state_in = bfscc_pkg::ST_SRC_WAIT;
                     end else begin
                        state_in = bfscc_pkg::ST_NCLR;
                     end
                  end
                  bfscc_pkg::REQ_CLEAR: begin
                     etot_in  = '0;
                     state_in = bfscc_pkg::ST_MCLR;
                  end
                  default: state_in = bfscc_pkg::ST_OUT;
               endcase
            end
         end

         bfscc_pkg::ST_SRC_WAIT: state_in = bfscc_pkg::ST_SRC_CHK;

         bfscc_pkg::ST_SRC_CHK: begin
            if (!mem_q) begin
               stat_in  = bfscc_pkg::STAT_BAD_SRC;
               state_in = bfscc_pkg::ST_OUT;
            end else begin
               state_in = bfscc_pkg::ST_NCLR;
            end
         end

         // level store sweep
         bfscc_pkg::ST_NCLR: begin
            ent_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_last) begin
               clr_in   = '0;
               state_in = bfscc_pkg::ST_SRC_SET;
            end
         end

         bfscc_pkg::ST_SRC_SET: begin
            ent_we    = 1'b1;
            ent_waddr = NODE_AW'(src_ff);
            ent_wdata = {1'b1, {bfscc_pkg::LVL_W{1'b0}}};
            lvl_in    = '0;
            chg_in    = 1'b0;
            eidx_in   = '0;
            scan_in   = '0;
            state_in  = (etot_ff == '0) ? bfscc_pkg::ST_ACC_RD : bfscc_pkg::ST_E_RD;
         end

         bfscc_pkg::ST_E_RD: state_in = bfscc_pkg::ST_E_A;

         bfscc_pkg::ST_E_A: begin
            if (e_ok) begin
               state_in = bfscc_pkg::ST_E_B;
            end else if (eidx_ff + 1'b1 == etot_ff) begin
               eidx_in  = '0;
               state_in = bfscc_pkg::ST_LVL_END;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = bfscc_pkg::ST_E_RD;
            end
         end

         bfscc_pkg::ST_E_B: begin
            enta_in  = ent_q;
            state_in = bfscc_pkg::ST_E_UPD;
         end

         // extend the frontier across one edge
         bfscc_pkg::ST_E_UPD: begin
            if (a_cur && !ent_q[bfscc_pkg::LVL_W]) begin
               ent_we    = 1'b1;
               ent_waddr = NODE_AW'(e_b);
               ent_wdata = {1'b1, lvl_ff + 1'b1};
               chg_in    = 1'b1;
            end else if (b_cur && !enta_ff[bfscc_pkg::LVL_W]) begin
               ent_we    = 1'b1;
               ent_waddr = NODE_AW'(e_a);
               ent_wdata = {1'b1, lvl_ff + 1'b1};
               chg_in    = 1'b1;
            end
            if (eidx_ff + 1'b1 == etot_ff) begin
               eidx_in  = '0;
               state_in = bfscc_pkg::ST_LVL_END;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = bfscc_pkg::ST_E_RD;
            end
         end

         bfscc_pkg::ST_LVL_END: begin
            if (chg_ff) begin
               lvl_in   = lvl_ff + 1'b1;
               chg_in   = 1'b0;
               state_in = bfscc_pkg::ST_E_RD;
            end else begin
               scan_in  = '0;
               state_in = bfscc_pkg::ST_ACC_RD;
            end
         end

         bfscc_pkg::ST_ACC_RD: state_in = bfscc_pkg::ST_ACC_CHK;

         // per-node accumulation
         bfscc_pkg::ST_ACC_CHK: begin
            if (counted) begin
               total_in = total_ff + 1'b1;
            end
            if (reached) begin
               reach_in  = reach_ff + 1'b1;
               sum_in    = sum_ff + bfscc_pkg::SUM_W'(ent_q[bfscc_pkg::LVL_W-1:0]);
               div_start = 1'b1;
               div_num   = hyp_ff ? bfscc_pkg::DIV_NW'(40'h200_0000)
                                  : bfscc_pkg::DIV_NW'(40'h100_0000);
               div_den   = bfscc_pkg::DIV_DW'(ent_q[bfscc_pkg::LVL_W-1:0]);
               state_in  = bfscc_pkg::ST_ACC_DIV;
            end else if (scan_ff + 1'b1 == neff) begin
               state_in = bfscc_pkg::ST_FAR;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = bfscc_pkg::ST_ACC_RD;
            end
         end

         bfscc_pkg::ST_ACC_DIV: begin
            if (div_done) begin
               hsum_in = hsum_ff + bfscc_pkg::HSUM_W'(div_quo);
               if (scan_ff + 1'b1 == neff) begin
                  state_in = bfscc_pkg::ST_FAR;
               end else begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = bfscc_pkg::ST_ACC_RD;
               end
            end
         end

         // farness = sum of levels / reached
         bfscc_pkg::ST_FAR: begin
            if (reach_ff != '0) begin
               div_start = 1'b1;
               div_num   = hyp_ff ? {5'b0, sum_ff, 15'b0} : {4'b0, sum_ff, 16'b0};
               div_den   = bfscc_pkg::DIV_DW'(reach_ff);
               state_in  = bfscc_pkg::ST_FAR_W;
            end else begin
               state_in = bfscc_pkg::ST_CLO;
            end
         end

         bfscc_pkg::ST_FAR_W: begin
            if (div_done) begin
               far_in   = (div_quo > bfscc_pkg::DIV_NW'(bfscc_pkg::FAR_MAX))
                          ? bfscc_pkg::FAR_MAX : div_quo[bfscc_pkg::FAR_W-1:0];
               state_in = bfscc_pkg::ST_CLO;
            end
         end

         // closeness = 1 / farness
         bfscc_pkg::ST_CLO: begin
            if (far_ff != '0) begin
               div_start = 1'b1;
               div_num   = bfscc_pkg::DIV_NW'(40'h1_0000_0000);
               div_den   = far_ff;
               state_in  = bfscc_pkg::ST_CLO_W;
            end else begin
               state_in = bfscc_pkg::ST_HARM;
            end
         end

         bfscc_pkg::ST_CLO_W: begin
            if (div_done) begin
               clo_in   = (div_quo > bfscc_pkg::DIV_NW'(bfscc_pkg::RATIO_MAX))
                          ? bfscc_pkg::RATIO_MAX : div_quo[bfscc_pkg::RATIO_W-1:0];
               state_in = bfscc_pkg::ST_HARM;
            end
         end

         // harmonic = term sum / ((total - 1) * 256)
         bfscc_pkg::ST_HARM: begin
            if (total_ff > bfscc_pkg::CNT_W'(1)) begin
               div_start = 1'b1;
               div_num   = bfscc_pkg::DIV_NW'(hsum_ff);
               div_den   = bfscc_pkg::DIV_DW'({total_ff - 1'b1, 8'b0});
               state_in  = bfscc_pkg::ST_HARM_W;
            end else begin
               state_in = bfscc_pkg::ST_OUT;
            end
         end

         bfscc_pkg::ST_HARM_W: begin
            if (div_done) begin
               harm_in  = (div_quo > bfscc_pkg::DIV_NW'(bfscc_pkg::RATIO_MAX))
                          ? bfscc_pkg::RATIO_MAX : div_quo[bfscc_pkg::RATIO_W-1:0];
               state_in = bfscc_pkg::ST_OUT;
            end
         end

         // hand the word to the output register
         bfscc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = bfscc_pkg::ST_IDLE;
            end
         end

         default: state_in = bfscc_pkg::ST_IDLE;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfscc_pkg::ST_RST_CLR;
         hyp_ff       <= 1'b0;
         ncount_ff    <= '0;
         etot_ff      <= '0;
         eidx_ff      <= '0;
         clr_ff       <= '0;
         lvl_ff       <= '0;
         chg_ff       <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hyp_ff       <= hyp_in;
         ncount_ff    <= ncount_in;
         etot_ff      <= etot_in;
         eidx_ff      <= eidx_in;
         clr_ff       <= clr_in;
         lvl_ff       <= lvl_in;
         chg_ff       <= chg_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working values and output payload
   always_ff @(posedge clock) begin
      src_ff   <= src_in;
      enta_ff  <= enta_in;
      total_ff <= total_in;
      reach_ff <= reach_in;
      sum_ff   <= sum_in;
      hsum_ff  <= hsum_in;
      far_ff   <= far_in;
      clo_ff   <= clo_in;
      harm_ff  <= harm_in;
      stat_ff  <= stat_in;
      if (rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_far_ff    <= far_ff;
         rsp_clo_ff    <= clo_ff;
         rsp_harm_ff   <= harm_ff;
         rsp_reach_ff  <= reach_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_farness_value   = rsp_far_ff;
   assign rsp_closeness_value = rsp_clo_ff;
   assign rsp_harmonic_value  = rsp_harm_ff;
   assign rsp_reachable_count = rsp_reach_ff;

   // edge list
   bfscc_ram #(
      .WIDTH (2 * bfscc_pkg::NODE_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (EDGE_AW'(etot_ff)),
      .wr_data ({req_node_a, req_node_b}),
      .rd_addr (EDGE_AW'(eidx_ff)),
      .rd_data (edge_q)
   );

   // member marks
   bfscc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_NODES)
   ) u_member_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   // visited flag and level per node
   bfscc_ram #(
      .WIDTH (bfscc_pkg::ENT_W),
      .DEPTH (MAX_NODES)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_q)
   );

   bfscc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

endmodule

`default_nettype wire

>>> tb/tb_bfs_closeness_harmonic_centrality_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bfs_closeness_harmonic_centrality_top: centrality search block testbench
// Loads small random graphs, queries sources in plain and hypergraph mode, and
// checks every response word against a behavioral BFS predictor in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bfs_closeness_harmonic_centrality_top;

   localparam int NODES     = 1024;
   localparam int EDGES     = 8192;
   localparam int CYCLE_CAP = 4000000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]                   kind;
      logic [bfscc_pkg::NODE_W-1:0] a;
      logic [bfscc_pkg::NODE_W-1:0] b;
      logic                         mark;
   } graph_req_type;

   typedef struct packed {
      logic [bfscc_pkg::STATUS_W-1:0] status;
      logic [bfscc_pkg::FAR_W-1:0]    far;
      logic [bfscc_pkg::RATIO_W-1:0]  clo;
      logic [bfscc_pkg::RATIO_W-1:0]  harm;
      logic [bfscc_pkg::REACH_W-1:0]  reach;
   } centrality_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = '0;
   logic [bfscc_pkg::NODE_W-1:0] req_node_a = '0, req_node_b = '0;
   logic req_mark_a = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [bfscc_pkg::STATUS_W-1:0] rsp_status;
   logic [bfscc_pkg::FAR_W-1:0] rsp_farness_value;
   logic [bfscc_pkg::RATIO_W-1:0] rsp_closeness_value, rsp_harmonic_value;
   logic [bfscc_pkg::REACH_W-1:0] rsp_reachable_count;
   logic csr_wr_en = 1'b0;
   logic csr_index = bfscc_pkg::CSR_HYP;
   logic [bfscc_pkg::CNT_W-1:0] csr_wdata = '0;

   bfs_closeness_harmonic_centrality_top uut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [bfscc_pkg::NODE_W-1:0] edge_a [EDGES];
   logic [bfscc_pkg::NODE_W-1:0] edge_b [EDGES];
   int unsigned       edge_cnt;
   bit                member [NODES];
   bit                hyp_mode;
   int unsigned       ncount;

   graph_req_type  pending_reqs[$];
   centrality_type expected_rsps[$];
   int unsigned errors = 0;
   bit          hold_off = 1'b0;
   bit          req_taken = 1'b0;
   longint unsigned cycles = 0;

   // BFS centrality of one request, updating graph state
   function automatic centrality_type predict_centrality(graph_req_type r);
      centrality_type res;
      int unsigned neff, head, tail, u, v;
      int unsigned lvl [NODES];
      bit seen [NODES];
      int unsigned fifo [NODES];
      longint unsigned sum_lev, hsum, total, reach, far, clo, harm, unit;
      res = '0;
      neff = (ncount < NODES) ? ncount : NODES;
      case (r.kind)
         bfscc_pkg::REQ_ADD: begin
            if (edge_cnt >= EDGES) res.status = bfscc_pkg::STAT_FULL;
            else begin
               edge_a[edge_cnt] = r.a;
               edge_b[edge_cnt] = r.b;
               edge_cnt++;
               if (r.mark) member[r.a] = 1'b1;
            end
         end
         bfscc_pkg::REQ_CLEAR: begin
            edge_cnt = 0;
            foreach (member[i]) member[i] = 1'b0;
         end
         bfscc_pkg::REQ_QUERY: begin
            if (r.a >= neff || (hyp_mode && !member[r.a]))
               res.status = bfscc_pkg::STAT_BAD_SRC;
            else begin
               foreach (seen[i]) begin
                  seen[i] = 1'b0;
                  lvl[i] = 0;
               end
               seen[r.a] = 1'b1;
               head = 0;
               tail = 1;
               fifo[0] = r.a;
               // adjacency order does not change levels, so scan edges directly
               while (head < tail) begin
                  u = fifo[head++];
                  for (int e = 0; e < edge_cnt; e++) begin
                     v = NODES;
                     if (edge_a[e] == u) v = edge_b[e];
                     else if (edge_b[e] == u) v = edge_a[e];
                     if (v < NODES && !seen[v]) begin
                        seen[v] = 1'b1;
                        lvl[v] = lvl[u] + 1;
                        fifo[tail++] = v;
                     end
                     // self loop appears twice in adjacency; harmless
                  end
               end
               unit = hyp_mode ? (64'd1 << 25) : (64'd1 << 24);
               sum_lev = 0; hsum = 0; total = 0; reach = 0;
               for (int n = 0; n < neff; n++) begin
                  if (!(hyp_mode && !member[n])) begin
                     total++;
                     if (seen[n] && n != r.a && lvl[n] > 0) begin
                        reach++;
                        sum_lev += lvl[n];
                        hsum += unit / lvl[n];
                     end
                  end
               end
               far = 0; clo = 0; harm = 0;
               if (reach > 0) begin
                  far = (sum_lev << (hyp_mode ? 15 : 16)) / reach;
                  if (far > bfscc_pkg::FAR_MAX) far = bfscc_pkg::FAR_MAX;
               end
               if (far > 0) begin
                  clo = (64'd1 << 32) / far;
                  if (clo > bfscc_pkg::RATIO_MAX) clo = bfscc_pkg::RATIO_MAX;
               end
               if (total > 1) begin
                  harm = hsum / ((total - 1) * 256);
                  if (harm > bfscc_pkg::RATIO_MAX) harm = bfscc_pkg::RATIO_MAX;
               end
               if (reach > 1023) reach = 1023;
               res.far = bfscc_pkg::FAR_W'(far);
               res.clo = bfscc_pkg::RATIO_W'(clo);
               res.harm = bfscc_pkg::RATIO_W'(harm);
               res.reach = bfscc_pkg::REACH_W'(reach);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // request accepted at this rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // request driver: bursts with random gaps
   int unsigned burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold word
         end else if (hold_off || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            graph_req_type r;
            r = pending_reqs.pop_front();
            expected_rsps.insert(expected_rsps.size(), predict_centrality(r));
            req_valid <= 1'b1;
            req_type <= r.kind;
            req_node_a <= r.a;
            req_node_b <= r.b;
            req_mark_a <= r.mark;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else burst_left <= burst_left - 1;
         end
      end
   end

   // response stall pattern
   int unsigned stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // response monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response status=%0d", $realtime, rsp_status);
            errors <= errors + 1;
         end else begin
            centrality_type x;
            x = expected_rsps.pop_front();
            if (x.status !== rsp_status || x.far !== rsp_farness_value ||
                x.clo !== rsp_closeness_value || x.harm !== rsp_harmonic_value ||
                x.reach !== rsp_reachable_count) begin
               $display("%0t: expected st=%0d far=%0d clo=%0d harm=%0d reach=%0d",
                        $realtime, x.status, x.far, x.clo, x.harm, x.reach);
               $display("%0t: actual   st=%0d far=%0d clo=%0d harm=%0d reach=%0d",
                        $realtime, rsp_status, rsp_farness_value, rsp_closeness_value,
                        rsp_harmonic_value, rsp_reachable_count);
               errors <= errors + 1;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] k, input int unsigned a, input int unsigned b,
                           input bit m);
      graph_req_type r;
      r.kind = k;
      r.a = bfscc_pkg::NODE_W'(a);
      r.b = bfscc_pkg::NODE_W'(b);
      r.mark = m;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic wait_drained();
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int unsigned val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bfscc_pkg::CNT_W'(val);
      if (idx == bfscc_pkg::CSR_HYP) hyp_mode = val[0];
      else ncount = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random graph phase: small node range, edge adds and queries interleaved
   task automatic random_phase(input int unsigned span, input int unsigned nitems);
      for (int i = 0; i < nitems; i++) begin
         int unsigned pick;
         pick = $urandom_range(0, 99);
         if (pick < 55)
            push_req(bfscc_pkg::REQ_ADD, $urandom_range(0, span - 1),
                     $urandom_range(0, span - 1), 1'($urandom_range(0, 1)));
         else if (pick < 92)
            push_req(bfscc_pkg::REQ_QUERY, $urandom_range(0, span), $urandom,
                     1'($urandom));
         else if (pick < 96)
            push_req(REQ_UNUSED, $urandom, $urandom, 1'($urandom));
         else
            push_req(bfscc_pkg::REQ_ADD, $urandom, $urandom, 1'($urandom));
      end
   endtask

   initial begin
      edge_cnt = 0;
      hyp_mode = 0;
      ncount = 0;
      foreach (member[i]) member[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: queries with zero node count, path, extremes
      push_req(bfscc_pkg::REQ_QUERY, 0, 0, 0);
      wait_drained();
      write_csr(bfscc_pkg::CSR_NCOUNT, 1024);
      write_csr(bfscc_pkg::CSR_HYP, 0);
      push_req(bfscc_pkg::REQ_QUERY, 1023, 0, 0);
      push_req(bfscc_pkg::REQ_ADD, 0, 1, 1);
      push_req(bfscc_pkg::REQ_ADD, 1, 2, 0);
      push_req(bfscc_pkg::REQ_ADD, 2, 3, 1);
      push_req(bfscc_pkg::REQ_ADD, 1023, 0, 1);
      push_req(bfscc_pkg::REQ_ADD, 5, 5, 0);
      push_req(bfscc_pkg::REQ_QUERY, 0, 1023, 1);
      push_req(bfscc_pkg::REQ_QUERY, 5, 0, 0);
      push_req(REQ_UNUSED, 1023, 1023, 1);
      push_req(bfscc_pkg::REQ_QUERY, 3, 0, 0);
      push_req(bfscc_pkg::REQ_CLEAR, 0, 0, 0);
      push_req(bfscc_pkg::REQ_QUERY, 0, 0, 0);
      wait_drained();

      // hypergraph: members 0,2 joined by hyperedge node 10
      write_csr(bfscc_pkg::CSR_HYP, 1);
      write_csr(bfscc_pkg::CSR_NCOUNT, 16);
      push_req(bfscc_pkg::REQ_ADD, 0, 10, 1);
      push_req(bfscc_pkg::REQ_ADD, 2, 10, 1);
      push_req(bfscc_pkg::REQ_ADD, 4, 11, 1);
      push_req(bfscc_pkg::REQ_QUERY, 0, 0, 0);
      push_req(bfscc_pkg::REQ_QUERY, 1, 0, 0);
      push_req(bfscc_pkg::REQ_QUERY, 10, 0, 0);
      push_req(bfscc_pkg::REQ_QUERY, 4, 0, 0);
      wait_drained();

      // random phases over several settings
      write_csr(bfscc_pkg::CSR_HYP, 0);
      write_csr(bfscc_pkg::CSR_NCOUNT, 12);
      push_req(bfscc_pkg::REQ_CLEAR, 0, 0, 0);
      random_phase(16, 30);
      wait_drained();
      hold_off = 1'b0;
      write_csr(bfscc_pkg::CSR_HYP, 1);
      write_csr(bfscc_pkg::CSR_NCOUNT, 20);
      random_phase(24, 30);
      wait_drained();
      write_csr(bfscc_pkg::CSR_HYP, 0);
      write_csr(bfscc_pkg::CSR_NCOUNT, 2047);
      push_req(bfscc_pkg::REQ_CLEAR, 0, 0, 0);
      random_phase(10, 25);
      wait_drained();
      write_csr(bfscc_pkg::CSR_NCOUNT, 1);
      random_phase(10, 15);
      wait_drained();

      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

>>> bfs_closeness_harmonic_centrality_top.f
sv/bfscc_pkg.sv
sv/bfscc_ram.sv
sv/bfscc_div.sv
sv/bfs_closeness_harmonic_centrality_top.sv
tb/tb_bfs_closeness_harmonic_centrality_top.sv
